@@ rtl/core/vip_pkg.sv @@
package vip_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PATH,
        PH_CONTOUR,
        PH_POINT,
        PH_STOP
    } t_phase;

    // Token kinds carried on the output stream.
    typedef enum logic [2:0] {
        TK_LAYER,
        TK_POINT,
        TK_EMPTY,
        TK_DONE,
        TK_BADMAGIC,
        TK_TRUNC
    } t_kind;

    // Record lengths in bytes.
    localparam logic [4:0] HEADER_LEN  = 5'd6;
    localparam logic [4:0] PATH_LEN    = 5'd20;
    localparam logic [4:0] CONTOUR_LEN = 5'd2;
    localparam logic [4:0] POINT_LEN   = 5'd4;
    localparam int         REC_DEPTH   = 20;

    // File magic, in file order.
    localparam logic [7:0] MAGIC_0 = 8'h54;
    localparam logic [7:0] MAGIC_1 = 8'h54;
    localparam logic [7:0] MAGIC_2 = 8'h49;
    localparam logic [7:0] MAGIC_3 = 8'h43;

    // Output token queue.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int OUT_DATA_W = 184;

    typedef struct packed {
        t_kind              kind;
        logic [63:0]        fill_rgba;
        logic [63:0]        stroke_rgba;
        logic signed [14:0] line_width;
        logic               bevel_join;
        logic signed [14:0] point_x;
        logic signed [14:0] point_y;
        logic [1:0]         point_kind;
        logic               contour_end;
        logic               path_end;
    } t_token;

    // Tokens produced by one accepted byte: up to two, in order.
    typedef struct packed {
        logic [1:0]       count;
        t_token [1:0]     tok;
    } t_push;

endpackage

@@ rtl/core/vip_parser.sv @@
module vip_parser
    import vip_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_first,
    input  logic       i_final,
    output t_push      o_push
);

    t_phase      r_phase, n_phase;
    logic [4:0]  r_bir, n_bir;
    logic [15:0] r_paths, n_paths;
    logic [15:0] r_contours, n_contours;
    logic [15:0] r_points, n_points;
    logic [7:0]  r_rec [REC_DEPTH];

    t_phase      w_ph;
    logic [4:0]  w_bi;
    logic [4:0]  w_need;
    logic [4:0]  w_idx;
    logic        w_active;
    logic        w_rec_done;
    logic [7:0]  w_view [REC_DEPTH];
    logic [15:0] w_c_dec;
    logic [15:0] w_p_dec;
    logic [15:0] w_word0, w_word2, w_hdr_paths, w_stroke, w_ncont;

    // Phase and byte position as seen by this byte; a first byte restarts.
    assign w_ph     = i_first ? PH_HEADER : r_phase;
    assign w_bi     = i_first ? 5'd0 : r_bir;
    assign w_active = (w_ph != PH_IDLE) && (w_ph != PH_STOP);

    always_comb begin
        unique case (w_ph)
            PH_HEADER:  w_need = HEADER_LEN;
            PH_PATH:    w_need = PATH_LEN;
            PH_CONTOUR: w_need = CONTOUR_LEN;
            default:    w_need = POINT_LEN;
        endcase
    end

    assign w_idx      = (w_bi >= w_need) ? 5'd0 : w_bi;
    assign w_rec_done = ((w_idx + 5'd1) == w_need);

    // Record view with the current byte in its slot.
    for (genvar g = 0; g < REC_DEPTH; g++) begin : g_view
        assign w_view[g] = (w_idx == 5'(g)) ? i_byte : r_rec[g];
    end

    assign w_word0     = {w_view[1], w_view[0]};
    assign w_word2     = {w_view[3], w_view[2]};
    assign w_hdr_paths = {w_view[5], w_view[4]};
    assign w_stroke    = {w_view[17], w_view[16]};
    assign w_ncont     = {w_view[19], w_view[18]};
    assign w_c_dec     = r_contours - 16'd1;
    assign w_p_dec     = r_paths - 16'd1;

    // Next state and tokens for one accepted byte.
    always_comb begin
        t_token     tk;
        logic [1:0] cnt;
        logic       cend;
        n_phase    = r_phase;
        n_bir      = r_bir;
        n_paths    = r_paths;
        n_contours = r_contours;
        n_points   = r_points;
        cnt        = 2'd0;
        cend       = 1'b0;
        tk         = '0;
        o_push     = '0;
        if (i_accept) begin
            if (i_first) begin
                n_phase = PH_HEADER;
                n_bir   = 5'd0;
            end
            if (w_active) begin
                n_bir = w_idx + 5'd1;
                if (w_rec_done) begin
                    n_bir = 5'd0;
                    unique case (w_ph)
                        PH_HEADER: begin
                            if (w_view[0] != MAGIC_0 || w_view[1] != MAGIC_1 ||
                                w_view[2] != MAGIC_2 || w_view[3] != MAGIC_3) begin
                                tk = '0;
                                tk.kind = TK_BADMAGIC;
                                o_push.tok[cnt[0]] = tk;
                                cnt = cnt + 2'd1;
                                n_phase = PH_STOP;
                            end else begin
                                n_paths = w_hdr_paths;
                                if (w_hdr_paths == 16'd0) begin
                                    tk = '0;
                                    tk.kind = TK_DONE;
                                    o_push.tok[cnt[0]] = tk;
                                    cnt = cnt + 2'd1;
                                    n_phase = PH_STOP;
                                end else begin
                                    n_phase = PH_PATH;
                                end
                            end
                        end
                        PH_PATH: begin
                            tk = '0;
                            tk.kind         = TK_LAYER;
                            tk.fill_rgba    = {w_view[7], w_view[6], w_view[5], w_view[4],
                                               w_view[3], w_view[2], w_view[1], w_view[0]};
                            tk.stroke_rgba  = {w_view[15], w_view[14], w_view[13],
                                               w_view[12], w_view[11], w_view[10],
                                               w_view[9], w_view[8]};
                            tk.line_width   = w_stroke[15:1];
                            tk.bevel_join   = w_stroke[0];
                            tk.path_end     = (w_ncont == 16'd0);
                            n_contours      = w_ncont;
                            o_push.tok[cnt[0]] = tk;
                            cnt = cnt + 2'd1;
                            if (w_ncont == 16'd0) begin
                                n_paths = w_p_dec;
                                if (w_p_dec == 16'd0) begin
                                    tk = '0;
                                    tk.kind = TK_DONE;
                                    o_push.tok[cnt[0]] = tk;
                                    cnt = cnt + 2'd1;
                                    n_phase = PH_STOP;
                                end
                            end else begin
                                n_phase = PH_CONTOUR;
                            end
                        end
                        PH_CONTOUR, PH_POINT: begin
                            if (w_ph == PH_CONTOUR) begin
                                n_points = w_word0;
                                if (w_word0 == 16'd0) begin
                                    tk = '0;
                                    tk.kind        = TK_EMPTY;
                                    tk.contour_end = 1'b1;
                                    tk.path_end    = (r_contours == 16'd1);
                                    o_push.tok[cnt[0]] = tk;
                                    cnt  = cnt + 2'd1;
                                    cend = 1'b1;
                                end else begin
                                    n_phase = PH_POINT;
                                end
                            end else begin
                                cend = (r_points == 16'd1);
                                tk = '0;
                                tk.kind        = TK_POINT;
                                tk.point_x     = w_word0[15:1];
                                tk.point_y     = w_word2[15:1];
                                tk.point_kind  = {w_word2[0], w_word0[0]};
                                tk.contour_end = cend;
                                tk.path_end    = cend && (r_contours == 16'd1);
                                o_push.tok[cnt[0]] = tk;
                                cnt      = cnt + 2'd1;
                                n_points = r_points - 16'd1;
                            end
                            // Contour finished: next contour, next path or done.
                            if (cend) begin
                                n_contours = w_c_dec;
                                if (w_c_dec != 16'd0) begin
                                    n_phase = PH_CONTOUR;
                                end else begin
                                    n_paths = w_p_dec;
                                    if (w_p_dec != 16'd0) begin
                                        n_phase = PH_PATH;
                                    end else begin
                                        tk = '0;
                                        tk.kind = TK_DONE;
                                        o_push.tok[cnt[0]] = tk;
                                        cnt = cnt + 2'd1;
                                        n_phase = PH_STOP;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                // Stream ended before the file was complete.
                if (i_final && n_phase != PH_STOP) begin
                    tk = '0;
                    tk.kind = TK_TRUNC;
                    o_push.tok[cnt[0]] = tk;
                    cnt = cnt + 2'd1;
                    n_phase = PH_STOP;
                    n_bir   = 5'd0;
                end
            end
        end
        o_push.count = cnt;
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bir      <= 5'd0;
            r_paths    <= 16'd0;
            r_contours <= 16'd0;
            r_points   <= 16'd0;
        end else begin
            r_phase    <= n_phase;
            r_bir      <= n_bir;
            r_paths    <= n_paths;
            r_contours <= n_contours;
            r_points   <= n_points;
        end
    end

    // Record byte store.
    always_ff @(posedge i_clk) begin
        if (i_accept && w_active) begin
            r_rec[w_idx] <= i_byte;
        end
    end

endmodule

@@ rtl/core/vip_token_queue.sv @@
module vip_token_queue
    import vip_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output t_token o_tok,
    output logic   o_valid,
    output logic   o_room
);

    t_token              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr, n_wr;
    logic [Q_PTR_W-1:0]  r_rd, n_rd;
    logic [Q_CNT_W-1:0]  r_cnt, n_cnt;
    logic                w_pop;
    logic [Q_PTR_W-1:0]  w_wr1;

    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_q[r_rd];
    // Room for the two tokens a single byte may produce.
    assign o_room  = (r_cnt <= Q_CNT_W'(Q_DEPTH - 2));
    assign w_pop   = i_pop && o_valid;
    assign w_wr1   = r_wr + Q_PTR_W'(1);

    always_comb begin
        n_wr  = r_wr + Q_PTR_W'(i_push.count);
        n_rd  = r_rd + Q_PTR_W'(w_pop);
        n_cnt = r_cnt + Q_CNT_W'(i_push.count) - Q_CNT_W'(w_pop);
    end

    // Pointer and fill registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Each entry takes the first or second pushed token when its slot is due.
    for (genvar g = 0; g < Q_DEPTH; g++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (i_push.count != 2'd0 && r_wr == Q_PTR_W'(g)) begin
                r_q[g] <= i_push.tok[0];
            end else if (i_push.count == 2'd2 && w_wr1 == Q_PTR_W'(g)) begin
                r_q[g] <= i_push.tok[1];
            end
        end
    end

endmodule

@@ rtl/core/vector_icon_stream_parser.sv @@
// A token is registered in the output queue before it is offered on the master side,
// behind any tokens queued ahead of it.
// One byte per cycle while the output queue has room for two tokens; a byte that yields
// two tokens is absorbed by the four-token output queue.
// Reset (synchronous, active low) returns the parser to idle and empties the queue;
// the record byte store is not cleared.
module vector_icon_stream_parser
    import vip_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // data_byte
    input  logic                  s_axis_tlast,   // final_byte
    input  logic                  s_axis_tuser,   // first_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // fill_rgba[63:0], stroke_rgba[127:64], line width[142:128], bevel_join[143],
    // point_x[158:144], point_y[173:159], point_kind[175:174], path_end[176], zeros
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,   // contour_end
    output logic [2:0]            m_axis_tuser    // token_kind
);

    t_push  w_push;
    t_token w_tok;
    logic   w_accept;
    logic   w_room;

    assign s_axis_tready = w_room;
    assign w_accept      = s_axis_tvalid && w_room;

    vip_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_first  (s_axis_tuser),
        .i_final  (s_axis_tlast),
        .o_push   (w_push)
    );

    vip_token_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (m_axis_tready),
        .o_tok   (w_tok),
        .o_valid (m_axis_tvalid),
        .o_room  (w_room)
    );

    // Output packing.
    assign m_axis_tdata = {7'd0, w_tok.path_end, w_tok.point_kind, w_tok.point_y,
                           w_tok.point_x, w_tok.bevel_join, w_tok.line_width,
                           w_tok.stroke_rgba, w_tok.fill_rgba};
    assign m_axis_tlast = w_tok.contour_end;
    assign m_axis_tuser = w_tok.kind;

endmodule

@@ dv/vector_icon_stream_parser_tb.sv @@
`timescale 1ns / 100ps

module vector_icon_stream_parser_tb;
    import vip_pkg::*;

    // Idling patterns applied to the two stream sides, one per phase of the run.
    typedef enum {
        MODE_STEADY,
        MODE_SEND_GAPS,
        MODE_RECV_STALLS,
        MODE_BOTH,
        MODE_HOLD
    } t_idle_mode;

    // One byte waiting to be offered on the slave side.
    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_file_byte;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BYTES  = 85;
    localparam int DRAIN_CYCLES = 8;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'h00;  // data_byte
    logic                  s_axis_tlast  = 1'b0;   // final_byte
    logic                  s_axis_tuser  = 1'b0;   // first_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // fill_rgba, stroke_rgba, line width, bevel_join, point_x, point_y,
    // point_kind, path_end, zeros
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;           // contour_end
    logic [2:0]            m_axis_tuser;           // token_kind

    vector_icon_stream_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_file_byte  bytes_to_send[$];
    t_token      tokens_due[$];
    logic [7:0]  file_image[$];
    t_idle_mode  idle_mode     = MODE_STEADY;
    logic        byte_accepted = 1'b0;
    logic        hold_armed    = 1'b1;
    int          hold_left     = 0;
    int          bytes_queued  = 0;
    int          bytes_taken   = 0;
    int          failures      = 0;
    int          cycle_count   = 0;

    // Shadow of the parser state.
    t_phase      parse_ph     = PH_IDLE;
    logic [4:0]  rec_fill     = '0;
    logic [7:0]  rec_mem [0:REC_DEPTH-1];
    logic [15:0] paths_rem    = '0;
    logic [15:0] contours_rem = '0;
    logic [15:0] points_rem   = '0;

    // Clock with a 2 ns period.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int send_gap_pct();
        case (idle_mode)
            MODE_SEND_GAPS: return 65;
            MODE_BOTH:      return 21;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (idle_mode)
            MODE_RECV_STALLS: return 65;
            MODE_BOTH:        return 21;
            default:          return 0;
        endcase
    endfunction

    // Appends a token of the given kind with every other field cleared.
    task automatic push_plain_token(input t_kind kind);
        t_token tok;
        tok = '0;
        tok.kind = kind;
        tokens_due.insert(tokens_due.size(), tok);
    endtask

    // A contour has closed: step to the next contour or path, or finish the file.
    task automatic close_contour();
        contours_rem = contours_rem - 16'd1;
        if (contours_rem != 16'd0) begin
            parse_ph = PH_CONTOUR;
        end else begin
            paths_rem = paths_rem - 16'd1;
            if (paths_rem != 16'd0) begin
                parse_ph = PH_PATH;
            end else begin
                push_plain_token(TK_DONE);
                parse_ph = PH_STOP;
            end
        end
    endtask

    // Works out the tokens that one accepted byte produces.
    task automatic predict_tokens(input logic [7:0] b, input logic first, input logic is_last);
        logic [4:0]  need;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic        cend;
        t_token      tok;
        if (first) begin
            parse_ph = PH_HEADER;
            rec_fill = '0;
        end
        if (parse_ph == PH_IDLE || parse_ph == PH_STOP) begin
            return;
        end
        case (parse_ph)
            PH_HEADER:  need = HEADER_LEN;
            PH_PATH:    need = PATH_LEN;
            PH_CONTOUR: need = CONTOUR_LEN;
            default:    need = POINT_LEN;
        endcase
        if (rec_fill >= need) begin
            rec_fill = '0;
        end
        rec_mem[rec_fill] = b;
        rec_fill = rec_fill + 5'd1;

        if (rec_fill == need) begin
            rec_fill = '0;
            tok = '0;
            case (parse_ph)
                PH_HEADER: begin
                    if (rec_mem[0] != MAGIC_0 || rec_mem[1] != MAGIC_1 ||
                        rec_mem[2] != MAGIC_2 || rec_mem[3] != MAGIC_3) begin
                        push_plain_token(TK_BADMAGIC);
                        parse_ph = PH_STOP;
                    end else begin
                        paths_rem = {rec_mem[5], rec_mem[4]};
                        if (paths_rem == 16'd0) begin
                            push_plain_token(TK_DONE);
                            parse_ph = PH_STOP;
                        end else begin
                            parse_ph = PH_PATH;
                        end
                    end
                end
                PH_PATH: begin
                    word_a = {rec_mem[17], rec_mem[16]};
                    contours_rem = {rec_mem[19], rec_mem[18]};
                    tok.kind = TK_LAYER;
                    for (int i = 0; i < 8; i++) begin
                        tok.fill_rgba[8*i +: 8]   = rec_mem[i];
                        tok.stroke_rgba[8*i +: 8] = rec_mem[8+i];
                    end
                    tok.line_width = word_a[15:1];
                    tok.bevel_join = word_a[0];
                    if (contours_rem == 16'd0) begin
                        // A path without contours closes on its own layer token.
                        tok.path_end = 1'b1;
                        tokens_due.insert(tokens_due.size(), tok);
                        paths_rem = paths_rem - 16'd1;
                        if (paths_rem == 16'd0) begin
                            push_plain_token(TK_DONE);
                            parse_ph = PH_STOP;
                        end
                    end else begin
                        tokens_due.insert(tokens_due.size(), tok);
                        parse_ph = PH_CONTOUR;
                    end
                end
                PH_CONTOUR: begin
                    points_rem = {rec_mem[1], rec_mem[0]};
                    if (points_rem == 16'd0) begin
                        tok.kind        = TK_EMPTY;
                        tok.contour_end = 1'b1;
                        tok.path_end    = (contours_rem == 16'd1);
                        tokens_due.insert(tokens_due.size(), tok);
                        close_contour();
                    end else begin
                        parse_ph = PH_POINT;
                    end
                end
                default: begin
                    word_a = {rec_mem[1], rec_mem[0]};
                    word_b = {rec_mem[3], rec_mem[2]};
                    cend   = (points_rem == 16'd1);
                    tok.kind        = TK_POINT;
                    tok.point_x     = word_a[15:1];
                    tok.point_y     = word_b[15:1];
                    tok.point_kind  = {word_b[0], word_a[0]};
                    tok.contour_end = cend;
                    tok.path_end    = cend && (contours_rem == 16'd1);
                    tokens_due.insert(tokens_due.size(), tok);
                    points_rem = points_rem - 16'd1;
                    if (cend) begin
                        close_contour();
                    end
                end
            endcase
        end

        // A final byte that leaves the file incomplete reports truncation.
        if (is_last && parse_ph != PH_STOP && parse_ph != PH_IDLE) begin
            push_plain_token(TK_TRUNC);
            parse_ph = PH_STOP;
            rec_fill = '0;
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want_v, got_v);
            failures++;
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic first, input logic is_last);
        t_file_byte item;
        item.data  = b;
        item.first = first;
        item.last  = is_last;
        bytes_to_send.insert(bytes_to_send.size(), item);
        bytes_queued++;
    endtask

    task automatic add_word(input logic [15:0] w);
        file_image.insert(file_image.size(), w[7:0]);
        file_image.insert(file_image.size(), w[15:8]);
    endtask

    // Random word, often one of the extremes of a Q1.13 value with either flag.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Builds one icon file, mostly well formed, sometimes corrupted, cut short
    // or replaced by noise, and queues its bytes.
    task automatic queue_icon_file();
        int   style;
        int   n_paths;
        int   n_cont;
        int   n_pts;
        int   keep;
        int   pos;
        bit   odd_counts;
        bit   cut_short;
        logic final_flag;
        style = $urandom_range(0, 99);
        if (style < 10) begin
            // Noise with random restart and final marks.
            repeat ($urandom_range(1, 12)) begin
                add_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
            end
            return;
        end
        odd_counts = (style >= 90);
        cut_short  = (style >= 75);
        file_image.delete();
        file_image.insert(file_image.size(), MAGIC_0);
        file_image.insert(file_image.size(), MAGIC_1);
        file_image.insert(file_image.size(), MAGIC_2);
        file_image.insert(file_image.size(), MAGIC_3);
        if (style >= 80 && style < 90) begin
            pos = $urandom_range(0, 3);
            file_image[pos] = file_image[pos] ^ 8'($urandom_range(1, 255));
        end
        n_paths = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
        add_word(odd_counts ? pick_word() : 16'(n_paths));
        if (odd_counts && n_paths == 0) begin
            n_paths = 1;
        end
        for (int p = 0; p < n_paths; p++) begin
            for (int c = 0; c < 8; c++) begin
                add_word(($urandom_range(0, 3) == 0) ? pick_word() : 16'($urandom));
            end
            add_word(pick_word());
            n_cont = $urandom_range(0, 2);
            add_word(odd_counts ? pick_word() : 16'(n_cont));
            for (int c = 0; c < n_cont; c++) begin
                n_pts = $urandom_range(0, 3);
                add_word(odd_counts ? pick_word() : 16'(n_pts));
                for (int k = 0; k < n_pts; k++) begin
                    add_word(pick_word());
                    add_word(pick_word());
                end
            end
        end
        keep = cut_short ? $urandom_range(1, file_image.size()) : file_image.size();
        final_flag = cut_short ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1) == 1);
        for (int i = 0; i < keep; i++) begin
            add_byte(file_image[i], i == 0, final_flag && (i == keep - 1));
        end
        // Stray bytes after the file, ignored unless parsing is still open.
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                add_byte(8'($urandom), 1'b0, $urandom_range(0, 1) == 1);
            end
        end
    endtask

    // Waits until every queued byte has been taken and every token has arrived.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (!(bytes_taken == bytes_queued && tokens_due.size() == 0 && !m_axis_tvalid));
    endtask

    // Slave-side driver: offers the next pending byte and holds it until taken.
    always @(negedge i_clk) begin : byte_driver
        t_file_byte item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || byte_accepted) begin
            if (bytes_to_send.size() != 0 && !chance(send_gap_pct())) begin
                item = bytes_to_send.pop_front();
                s_axis_tdata  <= item.data;
                s_axis_tuser  <= item.first;
                s_axis_tlast  <= item.last;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started once at the head of the pressure phase.
    always @(negedge i_clk) begin
        if (idle_mode == MODE_HOLD && hold_armed) begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Master-side ready with random stalls.
    always @(negedge i_clk) begin
        m_axis_tready <= (hold_left == 0) && !chance(recv_stall_pct());
    end

    // Monitor: predicts on every byte transfer and checks every token transfer.
    always @(posedge i_clk) begin : token_monitor
        t_token seen;
        t_token want;
        byte_accepted <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_tokens(s_axis_tdata, s_axis_tuser, s_axis_tlast);
                bytes_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen.kind         = t_kind'(m_axis_tuser);
                seen.fill_rgba    = m_axis_tdata[63:0];
                seen.stroke_rgba  = m_axis_tdata[127:64];
                seen.line_width   = m_axis_tdata[142:128];
                seen.bevel_join   = m_axis_tdata[143];
                seen.point_x      = m_axis_tdata[158:144];
                seen.point_y      = m_axis_tdata[173:159];
                seen.point_kind   = m_axis_tdata[175:174];
                seen.path_end     = m_axis_tdata[176];
                seen.contour_end  = m_axis_tlast;
                if (tokens_due.size() == 0) begin
                    $display("%0t ns: token with none expected, expected nothing, actual kind %0d",
                             $time, m_axis_tuser);
                    failures++;
                end else begin
                    want = tokens_due.pop_front();
                    compare_field("token kind", want.kind, seen.kind);
                    compare_field("fill colour", want.fill_rgba, seen.fill_rgba);
                    compare_field("stroke colour", want.stroke_rgba, seen.stroke_rgba);
                    compare_field("stroke width", want.line_width, seen.line_width);
                    compare_field("bevel join", want.bevel_join, seen.bevel_join);
                    compare_field("point x", want.point_x, seen.point_x);
                    compare_field("point y", want.point_y, seen.point_y);
                    compare_field("point kind", want.point_kind, seen.point_kind);
                    compare_field("contour end", want.contour_end, seen.contour_end);
                    compare_field("path end", want.path_end, seen.path_end);
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        int phase_start;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bytes while idle, a bad magic, an empty file closed by its
        // final byte, a byte after done and a header cut short.
        add_byte(8'hA5, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b1);
        add_byte(MAGIC_0, 1'b1, 1'b0);
        add_byte(MAGIC_1, 1'b0, 1'b0);
        add_byte(MAGIC_2, 1'b0, 1'b0);
        add_byte(8'h58, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(MAGIC_0, 1'b1, 1'b0);
        add_byte(MAGIC_1, 1'b0, 1'b0);
        add_byte(MAGIC_2, 1'b0, 1'b0);
        add_byte(MAGIC_3, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b1);
        add_byte(MAGIC_0, 1'b0, 1'b1);
        add_byte(MAGIC_0, 1'b1, 1'b0);
        add_byte(MAGIC_1, 1'b0, 1'b1);
        wait_drained();

        // Random files under each idling pattern, the long hold-off last.
        for (int m = MODE_STEADY; m <= MODE_HOLD; m++) begin
            @(posedge i_clk);
            idle_mode = t_idle_mode'(m);
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < PHASE_BYTES) begin
                queue_icon_file();
            end
            wait_drained();
        end

        @(posedge i_clk);
        idle_mode = MODE_STEADY;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (tokens_due.size() != 0) begin
            $display("%0t ns: %0d tokens never arrived, expected kind %0d first, actual none",
                     $time, tokens_due.size(), tokens_due[0].kind);
            failures++;
        end
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
